[sv/dplm_pkg.sv]
// Shared constants, codes and sequencer states for the demand-paging MMU.
// No dependencies; imported by every module of the block that needs it.
package dplm_pkg;

  localparam int PROCS  = 4;
  localparam int PAGES  = 16;
  localparam int FRAMES = 32;

  localparam int PID_W   = 2;                        // process_id field width
  localparam int PAGE_W  = 4;                        // page_number field width
  localparam int LIM_W   = 5;                        // page_limit field width
  localparam int FRAME_W = 5;                        // frame_number field width
  localparam int USE_W   = 32;                       // access clock / timestamp
  localparam int FLT_W   = 16;                       // fault counter
  localparam int CNT_W   = 3;                        // process_count / ended counter
  localparam int CFG_W   = 6;                        // widest config register
  localparam int ENT_N   = PROCS * PAGES;
  localparam int ENT_AW  = $clog2(ENT_N);
  localparam int PG_IW   = $clog2(PAGES);            // page index inside a process
  localparam int SCAN_W  = $clog2(PAGES + 1);        // scan counter, holds PAGES
  localparam int FS_AW   = $clog2(FRAMES);           // free stack address
  localparam int FC_W    = $clog2(FRAMES + 1);       // free count, holds FRAMES
  localparam int PT_W    = FRAME_W + USE_W;          // page table word

  localparam logic [FLT_W-1:0] FLT_MAX   = '1;
  localparam logic [CNT_W-1:0] ENDED_MAX = '1;

  typedef enum logic [1:0] {
    OP_ACCESS = 2'd0,
    OP_END    = 2'd1,
    OP_CONFIG = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_FAULT   = 3'd1,
    ST_INVALID = 3'd2,
    ST_ENDED   = 3'd3,
    ST_NOFRAME = 3'd4,
    ST_CONFIG  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    NT_NONE     = 2'd0,
    NT_BLOCKED  = 2'd1,
    NT_FINISHED = 2'd2
  } notice_t;

  typedef enum logic {
    CFG_PROC_COUNT = 1'b0,
    CFG_FREE_INIT  = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HIT_RD,
    S_HIT_WB,
    S_SCAN,
    S_VICTIM,
    S_POP_RD,
    S_POP_WT,
    S_MAP,
    S_REL,
    S_DONE
  } state_t;

endpackage

[sv/dplm_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dplm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/demand_paging_lru_mmu_unit.sv]
// Top level of the demand-paging MMU: per-process page table, free-frame stack, LRU eviction.
// Depends on dplm_pkg and dplm_ram (page table RAM and free stack RAM).
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------------
//  in      | into      | in_valid/in_stall  | operation process_id page_number page_limit
//          |           |                    | replace_locally
//  out     | out of    | out_valid/out_stall| status frame_number fault_count scheduler_notice
//          |           |                    | all_terminated
//  cfg     | into      | cfg_we             | cfg_index cfg_data
//
// One item at a time; the steps below run from accepting an item to raising out_valid.
// Configure: straight to the result. Hit: page table read, then write back. Fault from the
// free stack: pop read, pop wait, map. Fault with eviction: scan, victim, map, the scan over
// PL pages, PL the page limit of the process (one page table read per cycle, each compare in
// the cycle after its read); when no page is valid a free frame is popped instead.
// End or invalid reference: one page table read and at most one stack push per cycle.
// Reset is synchronous; all valid bits clear at once, so no clearing pass is needed.
// The result register holds a finished item under out_stall while the next item is taken.
module demand_paging_lru_mmu_unit
  import dplm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [PID_W-1:0]   process_id,
  input  logic [PAGE_W-1:0]  page_number,
  input  logic [LIM_W-1:0]   page_limit,
  input  logic               replace_locally,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [FRAME_W-1:0] frame_number,
  output logic [FLT_W-1:0]   fault_count,
  output logic [1:0]         scheduler_notice,
  output logic               all_terminated,
  // configuration
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  state_t state, state_next;

  // captured request
  logic [PID_W-1:0]   pid_r;
  logic [PAGE_W-1:0]  page_r;

  // process table (small, in flops)
  logic [LIM_W-1:0]   plim   [PROCS];
  logic               plocal [PROCS];
  logic [FLT_W-1:0]   pfaults[PROCS];

  logic [USE_W-1:0]   access_clock;
  logic [FC_W-1:0]    free_count;
  logic [CNT_W-1:0]   ended;
  logic [CNT_W-1:0]   proc_count;

  // valid bits: page table entries and free stack slots (unset slot i reads as frame i)
  logic [ENT_N-1:0]   ent_vld;
  logic [FRAMES-1:0]  stk_vld;

  // scan engine
  logic [SCAN_W-1:0]  scan_pg;
  logic               rd_pend;
  logic [PG_IW-1:0]   rd_pg;
  logic               best_found;
  logic [PG_IW-1:0]   best_pg;
  logic [USE_W-1:0]   best_use;
  logic [FRAME_W-1:0] best_frame;

  logic [FS_AW-1:0]   pop_idx;
  logic [FRAME_W-1:0] fno_r;

  // pending result
  status_t            res_status;
  logic [FRAME_W-1:0] res_frame;
  notice_t            res_notice;

  // RAM ports
  logic               pt_we;
  logic [ENT_AW-1:0]  pt_waddr, pt_raddr;
  logic [PT_W-1:0]    pt_wdata, pt_rdata;
  logic               fs_we;
  logic [FS_AW-1:0]   fs_waddr, fs_raddr;
  logic [FRAME_W-1:0] fs_wdata, fs_rdata;

  // derived
  logic [ENT_AW-1:0]  ent_idx, in_idx, scan_addr;
  logic [SCAN_W-1:0]  scan_lim;
  logic               scan_live, scan_ev;
  logic [FRAME_W-1:0] rd_frame;
  logic [USE_W-1:0]   rd_use;
  logic               in_take, out_free, in_bad;

  assign ent_idx   = {pid_r, page_r};
  assign in_idx    = {process_id, page_number};
  assign scan_addr = {pid_r, scan_pg[PG_IW-1:0]};
  assign scan_lim  = (state == S_REL) ? SCAN_W'(PAGES) : SCAN_W'(plim[pid_r]);
  assign scan_live = scan_pg < scan_lim;
  assign scan_ev   = scan_live && ent_vld[scan_addr];
  assign rd_frame  = pt_rdata[PT_W-1:USE_W];
  assign rd_use    = pt_rdata[USE_W-1:0];
  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && (state == S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign in_bad    = {1'b0, page_number} >= plim[process_id];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (op_t'(operation))
            OP_CONFIG: state_next = S_DONE;
            OP_END:    state_next = S_REL;
            OP_ACCESS: begin
              if (in_bad) begin
                state_next = S_REL;
              end else if (ent_vld[in_idx]) begin
                state_next = S_HIT_RD;
              end else if (free_count == '0 || plocal[process_id]) begin
                state_next = S_SCAN;
              end else begin
                state_next = S_POP_RD;
              end
            end
            OP_NONE:   state_next = S_IDLE;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_HIT_RD: state_next = S_HIT_WB;
      S_HIT_WB: state_next = S_DONE;
      S_SCAN:   if (!scan_live && !rd_pend) state_next = S_VICTIM;
      S_VICTIM: begin
        if (best_found) state_next = S_MAP;
        else if (free_count != '0) state_next = S_POP_RD;
        else state_next = S_DONE;
      end
      S_POP_RD: state_next = S_POP_WT;
      S_POP_WT: state_next = S_MAP;
      S_MAP:    state_next = S_DONE;
      S_REL:    if (!scan_live && !rd_pend) state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // RAM controls
  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = ent_idx;
    pt_wdata = {fno_r, access_clock};
    pt_raddr = scan_addr;
    fs_we    = 1'b0;
    fs_waddr = free_count[FS_AW-1:0];
    fs_wdata = rd_frame;
    fs_raddr = FS_AW'(free_count - FC_W'(1));
    unique case (state)
      S_HIT_RD: pt_raddr = ent_idx;
      S_HIT_WB: begin
        pt_we    = 1'b1;
        pt_wdata = {rd_frame, access_clock};
      end
      S_MAP:    pt_we = 1'b1;
      S_REL:    fs_we = rd_pend && (free_count < FC_W'(FRAMES));
      default:  ;
    endcase
  end

  dplm_ram #(.WIDTH(PT_W), .DEPTH(ENT_N)) u_page_table (
    .clk  (clk),
    .we   (pt_we),
    .waddr(pt_waddr),
    .wdata(pt_wdata),
    .raddr(pt_raddr),
    .rdata(pt_rdata)
  );

  dplm_ram #(.WIDTH(FRAME_W), .DEPTH(FRAMES)) u_free_stack (
    .clk  (clk),
    .we   (fs_we),
    .waddr(fs_waddr),
    .wdata(fs_wdata),
    .raddr(fs_raddr),
    .rdata(fs_rdata)
  );

  // result valid and read-pending flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      // a read is outstanding when the scanned entry was valid
      rd_pend <= (state == S_SCAN || state == S_REL) && scan_ev;
    end
  end

  // control state and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      access_clock <= '0;
      free_count   <= FC_W'(FRAMES);
      ended        <= '0;
      proc_count   <= CNT_W'(PROCS);
      ent_vld      <= '0;
      stk_vld      <= '0;
      for (int p = 0; p < PROCS; p++) begin
        plim[p]    <= '0;
        plocal[p]  <= 1'b0;
        pfaults[p] <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_PROC_COUNT: proc_count <= cfg_data[CNT_W-1:0];
          CFG_FREE_INIT: begin
            free_count <= (cfg_data > CFG_W'(FRAMES)) ? FC_W'(FRAMES)
                                                      : FC_W'(cfg_data);
            stk_vld    <= '0;
          end
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            pid_r      <= process_id;
            page_r     <= page_number;
            scan_pg    <= '0;
            best_found <= 1'b0;
            res_frame  <= '0;
            res_notice <= NT_NONE;
            unique case (op_t'(operation))
              OP_CONFIG: begin
                plim[process_id]   <= (page_limit > LIM_W'(PAGES)) ? LIM_W'(PAGES)
                                                                   : page_limit;
                plocal[process_id] <= replace_locally;
                res_status         <= ST_CONFIG;
              end
              OP_END: begin
                res_status <= ST_ENDED;
                res_notice <= NT_FINISHED;
              end
              OP_ACCESS: begin
                access_clock <= access_clock + USE_W'(1);
                if (in_bad) begin
                  res_status <= ST_INVALID;
                  res_notice <= NT_FINISHED;
                end else if (!ent_vld[in_idx]) begin
                  if (pfaults[process_id] != FLT_MAX) begin
                    pfaults[process_id] <= pfaults[process_id] + FLT_W'(1);
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_HIT_WB: begin
          res_status <= ST_HIT;
          res_frame  <= rd_frame;
        end
        S_SCAN: begin
          // issue one read per cycle, compare the previous read's timestamp
          if (scan_live) scan_pg <= scan_pg + SCAN_W'(1);
          rd_pg   <= scan_pg[PG_IW-1:0];
          if (rd_pend && (!best_found || rd_use < best_use)) begin
            best_found <= 1'b1;
            best_pg    <= rd_pg;
            best_use   <= rd_use;
            best_frame <= rd_frame;
          end
        end
        S_VICTIM: begin
          if (best_found) begin
            ent_vld[{pid_r, best_pg}] <= 1'b0;
            fno_r <= best_frame;
          end else if (free_count == '0) begin
            res_status <= ST_NOFRAME;
          end
        end
        S_POP_RD: begin
          pop_idx    <= FS_AW'(free_count - FC_W'(1));
          free_count <= free_count - FC_W'(1);
        end
        S_POP_WT: fno_r <= stk_vld[pop_idx] ? fs_rdata : FRAME_W'(pop_idx);
        S_MAP: begin
          ent_vld[ent_idx] <= 1'b1;
          res_status       <= ST_FAULT;
          res_frame        <= fno_r;
          res_notice       <= NT_BLOCKED;
        end
        S_REL: begin
          if (scan_live) scan_pg <= scan_pg + SCAN_W'(1);
          if (scan_ev) ent_vld[scan_addr] <= 1'b0;
          if (fs_we) begin
            stk_vld[free_count[FS_AW-1:0]] <= 1'b1;
            free_count <= free_count + FC_W'(1);
          end
          if (!scan_live && !rd_pend && ended != ENDED_MAX) begin
            ended <= ended + CNT_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            status           <= res_status;
            frame_number     <= res_frame;
            fault_count      <= pfaults[pid_r];
            scheduler_notice <= res_notice;
            all_terminated   <= (ended >= proc_count);
          end
        end
        default: ;
      endcase
    end
  end

  // checks
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= FC_W'(FRAMES))
    else $error("free count beyond frame total");

  a_map_unmapped: assert property (@(posedge clk) disable iff (rst)
    state == S_MAP |-> !ent_vld[ent_idx])
    else $error("mapping a page that is already mapped");

  a_victim_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_VICTIM && best_found) |-> ent_vld[{pid_r, best_pg}])
    else $error("victim page not valid");

  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    state == S_HIT_RD |-> ent_vld[ent_idx])
    else $error("hit on an unmapped page");

endmodule

[bench/dplm_checker.sv]
// Scoreboard for the demand-paging MMU: mirrors page table, free stack and counters,
// predicts one result per accepted request but OP_NONE, and compares it. Depends on dplm_pkg.
module dplm_checker
  import dplm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [PID_W-1:0]   process_id,
  input  logic [PAGE_W-1:0]  page_number,
  input  logic [LIM_W-1:0]   page_limit,
  input  logic               replace_locally,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         status,
  input  logic [FRAME_W-1:0] frame_number,
  input  logic [FLT_W-1:0]   fault_count,
  input  logic [1:0]         scheduler_notice,
  input  logic               all_terminated,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t            st;
    logic [FRAME_W-1:0] frame;
    logic [FLT_W-1:0]   faults;
    notice_t            notice;
    logic               all_done;
  } mmu_result_t;

  mmu_result_t result_q[$];

  logic [FRAME_W-1:0] pt_frame[ENT_N];
  logic               pt_valid[ENT_N];
  logic [USE_W-1:0]   pt_use[ENT_N];
  logic [FRAME_W-1:0] stack[FRAMES];
  int                 stack_fill;
  int                 limit_of[PROCS];
  logic               local_of[PROCS];
  logic [FLT_W-1:0]   faults_of[PROCS];
  logic [USE_W-1:0]   use_clock;
  logic [CNT_W-1:0]   ended_n;
  logic [CNT_W-1:0]   proc_count;

  assign pending = result_q.size();

  function automatic void reload_stack(int n);
    for (int i = 0; i < FRAMES; i++) stack[i] = FRAME_W'(i);
    stack_fill = n > FRAMES ? FRAMES : n;
  endfunction

  function automatic void free_process(int p);
    for (int pg = 0; pg < PAGES; pg++) begin
      if (pt_valid[p*PAGES+pg]) begin
        if (stack_fill < FRAMES) begin
          stack[stack_fill] = pt_frame[p*PAGES+pg];
          stack_fill++;
        end
        pt_valid[p*PAGES+pg] = 1'b0;
      end
    end
    if (ended_n != ENDED_MAX) ended_n++;
  endfunction

  // oldest valid page below the limit, lowest page on a tie; -1 if none
  function automatic int oldest_page(int p);
    int best;
    best = -1;
    for (int pg = 0; pg < limit_of[p]; pg++)
      if (pt_valid[p*PAGES+pg] &&
          (best < 0 || pt_use[p*PAGES+pg] < pt_use[p*PAGES+best])) best = pg;
    return best;
  endfunction

  function automatic mmu_result_t translate(op_t op, int p, int pg, int lim, logic loc);
    mmu_result_t r;
    int e, v;
    logic got;
    r = '{st: ST_HIT, frame: '0, faults: '0, notice: NT_NONE, all_done: 1'b0};
    e = p * PAGES + pg;
    if (op == OP_CONFIG) begin
      limit_of[p] = lim > PAGES ? PAGES : lim;
      local_of[p] = loc;
      r.st = ST_CONFIG;
    end else if (op == OP_END) begin
      free_process(p);
      r.st = ST_ENDED;
      r.notice = NT_FINISHED;
    end else begin
      use_clock++;
      if (pg >= limit_of[p]) begin
        free_process(p);
        r.st = ST_INVALID;
        r.notice = NT_FINISHED;
      end else if (pt_valid[e]) begin
        pt_use[e] = use_clock;
        r.frame = pt_frame[e];
      end else begin
        got = 1'b0;
        if (faults_of[p] != FLT_MAX) faults_of[p]++;
        if (stack_fill == 0 || local_of[p]) begin
          v = oldest_page(p);
          if (v >= 0) begin
            pt_valid[p*PAGES+v] = 1'b0;
            r.frame = pt_frame[p*PAGES+v];
            got = 1'b1;
          end
        end
        if (!got && stack_fill > 0) begin
          stack_fill--;
          r.frame = stack[stack_fill];
          got = 1'b1;
        end
        if (got) begin
          pt_valid[e] = 1'b1;
          pt_use[e] = use_clock;
          pt_frame[e] = r.frame;
          r.st = ST_FAULT;
          r.notice = NT_BLOCKED;
        end else r.st = ST_NOFRAME;
      end
    end
    r.faults = faults_of[p];
    r.all_done = ended_n >= proc_count;
    return r;
  endfunction

  always @(posedge clk) begin
    mmu_result_t want;
    if (rst) begin
      result_q.delete();
      fail_count <= 0;
      for (int i = 0; i < ENT_N; i++) begin
        pt_frame[i] = '0; pt_valid[i] = 1'b0; pt_use[i] = '0;
      end
      for (int p = 0; p < PROCS; p++) begin
        limit_of[p] = 0; local_of[p] = 1'b0; faults_of[p] = '0;
      end
      use_clock = '0;
      ended_n = '0;
      proc_count = 3'd4;
      reload_stack(32);
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_PROC_COUNT) proc_count = cfg_data[CNT_W-1:0];
        else reload_stack(int'(cfg_data));
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("result with nothing expected: status %0d", status);
          fail_count <= fail_count + 1;
        end else begin
          want = result_q.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            fail_count <= fail_count + 1;
          end else if (frame_number !== want.frame) begin
            $error("frame_number: expected %0d, got %0d", want.frame, frame_number);
            fail_count <= fail_count + 1;
          end else if (fault_count !== want.faults) begin
            $error("fault_count: expected %0d, got %0d", want.faults, fault_count);
            fail_count <= fail_count + 1;
          end else if (scheduler_notice !== want.notice) begin
            $error("scheduler_notice: expected %0d, got %0d", want.notice,
                   scheduler_notice);
            fail_count <= fail_count + 1;
          end else if (all_terminated !== want.all_done) begin
            $error("all_terminated: expected %0d, got %0d", want.all_done,
                   all_terminated);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall && op_t'(operation) != OP_NONE)
        result_q.push_back(translate(op_t'(operation), int'(process_id),
                                     int'(page_number), int'(page_limit),
                                     replace_locally));
    end
  end
endmodule

[bench/tb.sv]
// Top of the MMU bench: clock, reset, request stimulus, register writes and verdict.
// Depends on dplm_pkg, dplm_checker and the demand_paging_lru_mmu_unit RTL.
module tb;
  import dplm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_stall;
  logic [1:0] operation = '0;
  logic [PID_W-1:0] process_id = '0;
  logic [PAGE_W-1:0] page_number = '0;
  logic [LIM_W-1:0] page_limit = '0;
  logic replace_locally = 1'b0;
  logic out_valid, out_stall = 1'b0;
  logic [2:0] status;
  logic [FRAME_W-1:0] frame_number;
  logic [FLT_W-1:0] fault_count;
  logic [1:0] scheduler_notice;
  logic all_terminated;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  int fail_count, pending;

  always #5 clk = ~clk;

  demand_paging_lru_mmu_unit dut (.*);
  dplm_checker chk (.*);

  // receiver stall pattern: switches between free-flowing, light and heavy stalling
  int stall_mode = 0;
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  int burst_left = 0;

  // one request; random gap before it when the current burst runs out
  task automatic send_request(op_t op, int p, int pg, int lim, logic loc);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    operation <= op;
    process_id <= PID_W'(p);
    page_number <= PAGE_W'(pg);
    page_limit <= LIM_W'(lim);
    replace_locally <= loc;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  // wait for every result, then let a full scan go by before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (PAGES + 10) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly accesses to configured pages; some ends, configs, wild pages, unused op
  task automatic random_request();
    int k, p;
    k = $urandom_range(0, 99);
    p = $urandom_range(0, PROCS - 1);
    if (k < 78)
      send_request(OP_ACCESS, p, $urandom_range(0, ($urandom_range(0, 9) == 0) ? 15 : 7),
                   $urandom_range(0, 31), $urandom_range(0, 1));
    else if (k < 88)
      send_request(OP_CONFIG, p, $urandom_range(0, 15),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) :
                   $urandom_range(4, 10), $urandom_range(0, 1));
    else if (k < 93)
      send_request(OP_END, p, $urandom_range(0, 15), $urandom_range(0, 31),
                   $urandom_range(0, 1));
    else
      send_request(OP_NONE, p, $urandom_range(0, 15), $urandom_range(0, 31),
                   $urandom_range(0, 1));
  endtask

  initial begin
    int free_set[4];
    int proc_set[4];
    free_set = '{32, 0, 5, 63};
    proc_set = '{4, 0, 7, 1};
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: configure, hits, faults, limit edge, local eviction, ends
    send_request(OP_CONFIG, 0, 0, 16, 1'b0);
    send_request(OP_CONFIG, 1, 15, 31, 1'b1);
    send_request(OP_CONFIG, 2, 0, 0, 1'b0);
    send_request(OP_CONFIG, 3, 0, 2, 1'b1);
    send_request(OP_ACCESS, 0, 0, 0, 1'b0);
    send_request(OP_ACCESS, 0, 15, 0, 1'b0);
    send_request(OP_ACCESS, 0, 0, 0, 1'b0);
    send_request(OP_ACCESS, 3, 0, 0, 1'b0);
    send_request(OP_ACCESS, 3, 1, 0, 1'b0);
    send_request(OP_ACCESS, 3, 0, 0, 1'b0);
    send_request(OP_ACCESS, 1, 15, 0, 1'b0);
    send_request(OP_ACCESS, 1, 3, 0, 1'b0);
    send_request(OP_ACCESS, 3, 1, 0, 1'b0);
    send_request(OP_ACCESS, 3, 2, 0, 1'b0);
    send_request(OP_ACCESS, 2, 0, 0, 1'b0);
    send_request(OP_NONE, 0, 0, 0, 1'b0);
    send_request(OP_END, 1, 0, 0, 1'b0);
    send_request(OP_END, 1, 0, 0, 1'b0);
    send_request(OP_END, 0, 0, 0, 1'b0);
    send_request(OP_ACCESS, 0, 3, 0, 1'b0);
    drain();

    // empty stack: eviction when possible, no-frame status otherwise
    write_reg(CFG_FREE_INIT, 0);
    write_reg(CFG_PROC_COUNT, 0);
    send_request(OP_CONFIG, 2, 0, 4, 1'b0);
    send_request(OP_ACCESS, 2, 1, 0, 1'b0);
    send_request(OP_ACCESS, 0, 1, 0, 1'b0);
    send_request(OP_ACCESS, 0, 2, 0, 1'b0);
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_FREE_INIT, free_set[ph]);
      write_reg(CFG_PROC_COUNT, proc_set[ph]);
      for (int p = 0; p < PROCS; p++)
        send_request(OP_CONFIG, p, 0, $urandom_range(3, 16), $urandom_range(0, 1));
      for (int i = 0; i < 400; i++) random_request();
      drain();
    end

    if (fail_count == 0)
      $display("demand_paging_lru_mmu_unit verification clean");
    else
      $display("demand_paging_lru_mmu_unit verification failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("demand_paging_lru_mmu_unit verification failed");
    $finish;
  end
endmodule

[filelist.f]
sv/dplm_pkg.sv
sv/dplm_ram.sv
sv/demand_paging_lru_mmu_unit.sv
bench/dplm_checker.sv
bench/tb.sv
